/* rtl/slt_pkg.sv */
package slt_pkg;

    // List geometry and result field sizes.
    localparam int DEPTH   = 16;
    localparam int MAX_OUT = 16;
    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int FW      = 5;
    localparam int VW      = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_DUMP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } res_status_t;

    // Datapath actions requested by the controller.
    typedef enum logic [3:0] {
        ACT_NONE      = 4'd0,
        ACT_LOAD      = 4'd1,
        ACT_FULL      = 4'd2,
        ACT_EMPTY     = 4'd3,
        ACT_INS_SHIFT = 4'd4,
        ACT_INS_PLACE = 4'd5,
        ACT_RM_KEEP   = 4'd6,
        ACT_RM_DROP   = 4'd7,
        ACT_RM_DONE   = 4'd8,
        ACT_SR_STEP   = 4'd9,
        ACT_SR_MATCH  = 4'd10,
        ACT_SR_DONE   = 4'd11,
        ACT_DUMP_STEP = 4'd12
    } act_t;

    typedef struct packed {
        act_t act;
        logic rd;
        logic rd_prev;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic idx_zero;
        logic idx_end;
        logic less;
        logic equal;
        logic slot_free;
        logic dump_last;
    } dp_stat_t;

    // Masks a count or position to the width of a result field.
    function automatic logic [FW-1:0] fit_field(input logic [CW:0] x);
        logic [15:0] w;
        w = 16'(x);
        return w[FW-1:0];
    endfunction

endpackage

/* rtl/slt_in_if.sv */
interface slt_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic signed [31:0] operand_value;

    modport source (output valid, output opcode, output operand_value, input ready);
    modport sink   (input valid, input opcode, input operand_value, output ready);
endinterface

/* rtl/slt_out_if.sv */
interface slt_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [4:0]         position;
    logic signed [31:0] entry_value;
    logic [4:0]         removed_count;
    logic [4:0]         fill_level;
    logic               last;

    modport source (output valid, output status, output position, output entry_value,
                    output removed_count, output fill_level, output last, input ready);
    modport sink   (input valid, input status, input position, input entry_value,
                    input removed_count, input fill_level, input last, output ready);
endinterface

/* rtl/sorted_list_table_top.sv */
// Channel   Role     Carries
// in_item   sink     opcode, operand_value
// result    source   status, position, entry_value, removed_count, fill_level, last
//
// One command is worked on at a time; in_item.ready is high only in the idle state.
// Each step through the list is a read state and then a compare or emit state, set by the
// single registered read port of the entry memory. Reset clears the fill level, the
// control registers and the result valid flag, but not the entry memory.
// A stalled result holds the sequence at the next result until the transfer ends.
module sorted_list_table_top (
    input  logic     clk,
    input  logic     rst_n,
    slt_in_if.sink   in_item,
    slt_out_if.source result
);

    slt_pkg::dp_cmd_t  cmd;
    slt_pkg::dp_stat_t stat;
    logic              in_ready;

    assign in_item.ready = in_ready;

    // Sequencer.
    slt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_item.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Entry store, counters and result register.
    slt_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (in_item.opcode),
        .operand_value (in_item.operand_value),
        .result        (result)
    );

endmodule

/* rtl/slt_datapath.sv */
module slt_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  slt_pkg::dp_cmd_t   cmd,
    output slt_pkg::dp_stat_t  stat,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] operand_value,
    slt_out_if.source          result
);

    // Entry store, single write port and registered read port.
    logic signed [slt_pkg::VW-1:0] mem [slt_pkg::DEPTH];
    logic signed [slt_pkg::VW-1:0] rdata_reg;
    logic signed [slt_pkg::VW-1:0] val_reg;

    slt_pkg::op_t          op_reg;
    logic [slt_pkg::CW-1:0] count_reg;
    logic [slt_pkg::CW-1:0] count_next;
    logic [slt_pkg::CW-1:0] idx_reg;
    logic [slt_pkg::CW-1:0] idx_next;
    logic [slt_pkg::CW-1:0] j_reg;
    logic [slt_pkg::CW-1:0] j_next;
    logic [slt_pkg::CW-1:0] pend_pos_reg;
    logic [slt_pkg::CW-1:0] pend_pos_next;
    logic                   pend_reg;
    logic                   pend_next;

    // Output register.
    logic                          out_valid_reg;
    logic                          out_valid_next;
    slt_pkg::res_status_t          out_status_reg;
    logic [slt_pkg::FW-1:0]        out_pos_reg;
    logic signed [slt_pkg::VW-1:0] out_val_reg;
    logic [slt_pkg::FW-1:0]        out_rem_reg;
    logic [slt_pkg::FW-1:0]        out_fill_reg;
    logic                          out_last_reg;

    logic [slt_pkg::CW-1:0] idx_dec;
    logic [slt_pkg::CW:0]   idx_inc;
    logic [slt_pkg::CW:0]   count_inc;
    logic [slt_pkg::CW-1:0] removed;
    logic [slt_pkg::AW-1:0] rd_addr;
    logic                   cnt_ok;
    logic                   dump_last;
    logic                   slot_free;

    logic                   wr_en;
    logic [slt_pkg::AW-1:0] wr_addr;
    logic signed [slt_pkg::VW-1:0] wr_data;

    logic                          emit;
    slt_pkg::res_status_t          e_status;
    logic [slt_pkg::CW:0]          e_pos;
    logic signed [slt_pkg::VW-1:0] e_val;
    logic [slt_pkg::CW:0]          e_rem;
    logic [slt_pkg::CW:0]          e_fill;
    logic                          e_last;

    // Index arithmetic and derived flags for the operations.
    assign idx_dec   = idx_reg - 1'b1;
    assign idx_inc   = {1'b0, idx_reg} + 1'b1;
    assign count_inc = {1'b0, count_reg} + 1'b1;
    assign removed   = count_reg - j_reg;
    assign rd_addr   = cmd.rd_prev ? idx_dec[slt_pkg::AW-1:0] : idx_reg[slt_pkg::AW-1:0];
    assign cnt_ok    = 32'(j_reg) < 32'(slt_pkg::MAX_OUT);
    assign dump_last = (idx_inc == {1'b0, count_reg}) ||
                       (32'(idx_inc) == 32'(slt_pkg::MAX_OUT));
    assign slot_free = !out_valid_reg || result.ready;

    // Status towards the controller.
    always_comb
    begin
        stat.op        = op_reg;
        stat.full      = count_reg == slt_pkg::CW'(slt_pkg::DEPTH);
        stat.empty     = count_reg == '0;
        stat.idx_zero  = idx_reg == '0;
        stat.idx_end   = idx_reg == count_reg;
        stat.less      = val_reg < rdata_reg;
        stat.equal     = val_reg == rdata_reg;
        stat.slot_free = slot_free;
        stat.dump_last = dump_last;
    end

    // Write port selection.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg[slt_pkg::AW-1:0];
        wr_data = rdata_reg;
        case (cmd.act)
            slt_pkg::ACT_INS_SHIFT:
            begin
                wr_en = 1'b1;
            end
            slt_pkg::ACT_INS_PLACE:
            begin
                wr_en   = 1'b1;
                wr_data = val_reg;
            end
            slt_pkg::ACT_RM_KEEP:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg[slt_pkg::AW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.act == slt_pkg::ACT_LOAD)
        begin
            val_reg <= operand_value;
        end
    end

    // Result assembly for the action in hand.
    always_comb
    begin
        emit     = 1'b0;
        e_status = slt_pkg::ST_OK;
        e_pos    = '0;
        e_val    = '0;
        e_rem    = '0;
        e_fill   = {1'b0, count_reg};
        e_last   = 1'b1;
        case (cmd.act)
            slt_pkg::ACT_FULL:
            begin
                emit     = 1'b1;
                e_status = slt_pkg::ST_FULL;
            end
            slt_pkg::ACT_EMPTY:
            begin
                emit     = 1'b1;
                e_status = slt_pkg::ST_EMPTY;
            end
            slt_pkg::ACT_INS_PLACE:
            begin
                emit   = 1'b1;
                e_pos  = idx_inc;
                e_val  = val_reg;
                e_fill = count_inc;
            end
            slt_pkg::ACT_RM_DONE:
            begin
                emit     = 1'b1;
                e_status = (removed == '0) ? slt_pkg::ST_NOT_FOUND : slt_pkg::ST_OK;
                e_rem    = {1'b0, removed};
                e_fill   = {1'b0, j_reg};
            end
            slt_pkg::ACT_SR_MATCH:
            begin
                emit   = pend_reg && cnt_ok;
                e_pos  = {1'b0, pend_pos_reg};
                e_val  = val_reg;
                e_last = 1'b0;
            end
            slt_pkg::ACT_SR_DONE:
            begin
                emit = 1'b1;
                if (pend_reg)
                begin
                    e_pos = {1'b0, pend_pos_reg};
                    e_val = val_reg;
                end
                else
                begin
                    e_status = slt_pkg::ST_NOT_FOUND;
                end
            end
            slt_pkg::ACT_DUMP_STEP:
            begin
                emit   = 1'b1;
                e_pos  = idx_inc;
                e_val  = rdata_reg;
                e_last = dump_last;
            end
            default:
            begin
            end
        endcase
    end

    // Next values of the list control registers.
    always_comb
    begin
        count_next    = count_reg;
        idx_next      = idx_reg;
        j_next        = j_reg;
        pend_next     = pend_reg;
        pend_pos_next = pend_pos_reg;
        case (cmd.act)
            slt_pkg::ACT_LOAD:
            begin
                idx_next  = (opcode == slt_pkg::OP_INSERT) ? count_reg : '0;
                j_next    = '0;
                pend_next = 1'b0;
            end
            slt_pkg::ACT_INS_SHIFT:
            begin
                idx_next = idx_dec;
            end
            slt_pkg::ACT_INS_PLACE:
            begin
                count_next = count_inc[slt_pkg::CW-1:0];
            end
            slt_pkg::ACT_RM_KEEP:
            begin
                j_next   = j_reg + 1'b1;
                idx_next = idx_inc[slt_pkg::CW-1:0];
            end
            slt_pkg::ACT_RM_DROP, slt_pkg::ACT_SR_STEP, slt_pkg::ACT_DUMP_STEP:
            begin
                idx_next = idx_inc[slt_pkg::CW-1:0];
            end
            slt_pkg::ACT_RM_DONE:
            begin
                count_next = j_reg;
            end
            slt_pkg::ACT_SR_MATCH:
            begin
                idx_next = idx_inc[slt_pkg::CW-1:0];
                if (cnt_ok)
                begin
                    pend_next     = 1'b1;
                    pend_pos_next = idx_inc[slt_pkg::CW-1:0];
                    j_next        = j_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid_next = emit ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= slt_pkg::OP_INSERT;
            count_reg     <= '0;
            idx_reg       <= '0;
            j_reg         <= '0;
            pend_reg      <= 1'b0;
            pend_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.act == slt_pkg::ACT_LOAD)
            begin
                op_reg <= slt_pkg::op_t'(opcode);
            end
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            j_reg         <= j_next;
            pend_reg      <= pend_next;
            pend_pos_reg  <= pend_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload is captured whenever a result is produced.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_status_reg <= e_status;
            out_pos_reg    <= slt_pkg::fit_field(e_pos);
            out_val_reg    <= e_val;
            out_rem_reg    <= slt_pkg::fit_field(e_rem);
            out_fill_reg   <= slt_pkg::fit_field(e_fill);
            out_last_reg   <= e_last;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = out_status_reg;
    assign result.position      = out_pos_reg;
    assign result.entry_value   = out_val_reg;
    assign result.removed_count = out_rem_reg;
    assign result.fill_level    = out_fill_reg;
    assign result.last          = out_last_reg;

    // A result is only produced when the output register can take it.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> slot_free)
        else $error("result produced while output register is occupied");

    // Placing an inserted value grows the list by exactly one.
    a_place_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.act == slt_pkg::ACT_INS_PLACE) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the list by one");

    // The insert scan never reads below the first entry.
    a_ins_read: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd && cmd.rd_prev) |-> !stat.idx_zero)
        else $error("insert scan read below the first entry");

    // During a remove the compaction pointer never passes the scan pointer.
    a_rm_order: assert property (@(posedge clk) disable iff (!rst_n)
        (op_reg == slt_pkg::OP_REMOVE) |-> (j_reg <= idx_reg))
        else $error("remove write pointer ran ahead of read pointer");

endmodule

/* rtl/slt_ctrl.sv */
module slt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  slt_pkg::dp_stat_t stat,
    output slt_pkg::dp_cmd_t  cmd
);

    typedef enum logic [13:0] {
        S_IDLE    = 14'h0001,
        S_START   = 14'h0002,
        S_REJECT  = 14'h0004,
        S_INS_RD  = 14'h0008,
        S_INS_CMP = 14'h0010,
        S_INS_PUT = 14'h0020,
        S_RM_RD   = 14'h0040,
        S_RM_CMP  = 14'h0080,
        S_RM_FIN  = 14'h0100,
        S_SR_RD   = 14'h0200,
        S_SR_CMP  = 14'h0400,
        S_SR_FIN  = 14'h0800,
        S_DP_RD   = 14'h1000,
        S_DP_EMIT = 14'h2000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Sequencing of each operation as read and compare (or emit) steps.
    always_comb
    begin
        state_next  = state_reg;
        cmd.act     = slt_pkg::ACT_NONE;
        cmd.rd      = 1'b0;
        cmd.rd_prev = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.act    = slt_pkg::ACT_LOAD;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (stat.op == slt_pkg::OP_INSERT)
                begin
                    state_next = stat.full ? S_REJECT : S_INS_RD;
                end
                else if (stat.empty)
                begin
                    state_next = S_REJECT;
                end
                else
                begin
                    case (stat.op)
                        slt_pkg::OP_REMOVE: state_next = S_RM_RD;
                        slt_pkg::OP_SEARCH: state_next = S_SR_RD;
                        default:            state_next = S_DP_RD;
                    endcase
                end
            end
            S_REJECT:
            begin
                if (stat.slot_free)
                begin
                    cmd.act    = (stat.op == slt_pkg::OP_INSERT) ?
                                 slt_pkg::ACT_FULL : slt_pkg::ACT_EMPTY;
                    state_next = S_IDLE;
                end
            end
            S_INS_RD:
            begin
                if (stat.idx_zero)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    cmd.rd      = 1'b1;
                    cmd.rd_prev = 1'b1;
                    state_next  = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (stat.less)
                begin
                    cmd.act    = slt_pkg::ACT_INS_SHIFT;
                    state_next = S_INS_RD;
                end
                else
                begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT:
            begin
                if (stat.slot_free)
                begin
                    cmd.act    = slt_pkg::ACT_INS_PLACE;
                    state_next = S_IDLE;
                end
            end
            S_RM_RD:
            begin
                if (stat.idx_end)
                begin
                    state_next = S_RM_FIN;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_RM_CMP;
                end
            end
            S_RM_CMP:
            begin
                cmd.act    = stat.equal ? slt_pkg::ACT_RM_DROP : slt_pkg::ACT_RM_KEEP;
                state_next = S_RM_RD;
            end
            S_RM_FIN:
            begin
                if (stat.slot_free)
                begin
                    cmd.act    = slt_pkg::ACT_RM_DONE;
                    state_next = S_IDLE;
                end
            end
            S_SR_RD:
            begin
                if (stat.idx_end)
                begin
                    state_next = S_SR_FIN;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_SR_CMP;
                end
            end
            S_SR_CMP:
            begin
                if (stat.less)
                begin
                    state_next = S_SR_FIN;
                end
                else if (stat.equal)
                begin
                    if (stat.slot_free)
                    begin
                        cmd.act    = slt_pkg::ACT_SR_MATCH;
                        state_next = S_SR_RD;
                    end
                end
                else
                begin
                    cmd.act    = slt_pkg::ACT_SR_STEP;
                    state_next = S_SR_RD;
                end
            end
            S_SR_FIN:
            begin
                if (stat.slot_free)
                begin
                    cmd.act    = slt_pkg::ACT_SR_DONE;
                    state_next = S_IDLE;
                end
            end
            S_DP_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_DP_EMIT;
            end
            S_DP_EMIT:
            begin
                if (stat.slot_free)
                begin
                    cmd.act    = slt_pkg::ACT_DUMP_STEP;
                    state_next = stat.dump_last ? S_IDLE : S_DP_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* bench/tb_sorted_list_table_top.sv */
module tb_sorted_list_table_top;

    localparam int RANDOM_ITEMS = 352;
    localparam int DRAIN_CYCLES = 120;
    localparam int MAX_PRINTED  = 40;

    // One result as the table should report it.
    typedef struct {
        slt_pkg::res_status_t            status;
        logic [slt_pkg::FW-1:0]          position;
        logic signed [slt_pkg::VW-1:0]   value;
        logic [slt_pkg::FW-1:0]          removed;
        logic [slt_pkg::FW-1:0]          fill;
        logic                            last;
    } outcome_t;

    // Mirror of the sorted table and the queue of results it should produce.
    class list_scoreboard;
        logic signed [slt_pkg::VW-1:0] slots [slt_pkg::DEPTH];
        int unsigned                   fill;
        outcome_t                      awaited [$];
        int                            errors;
        int                            checked;
        int                            refused;
        int                            peak_fill;
        int                            op_seen [4];

        function new();
            fill      = 0;
            errors    = 0;
            checked   = 0;
            refused   = 0;
            peak_fill = 0;
            foreach (op_seen[i]) op_seen[i] = 0;
        endfunction

        function outcome_t make(slt_pkg::res_status_t st, int unsigned pos,
                                logic signed [slt_pkg::VW-1:0] val, int unsigned rm);
            outcome_t o;
            o.status   = st;
            o.position = pos[slt_pkg::FW-1:0];
            o.value    = val;
            o.removed  = rm[slt_pkg::FW-1:0];
            o.fill     = fill[slt_pkg::FW-1:0];
            o.last     = 1'b0;
            return o;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Applies one accepted command to the mirror and queues its results.
        function void note_input(slt_pkg::op_t op, logic signed [slt_pkg::VW-1:0] val);
            outcome_t    batch [$];
            outcome_t    o;
            int unsigned i;
            int unsigned keep;
            int unsigned dropped;

            op_seen[op]++;
            if (op == slt_pkg::OP_INSERT)
            begin
                if (fill >= slt_pkg::DEPTH)
                begin
                    refused++;
                    batch.push_back(make(slt_pkg::ST_FULL, 0, '0, 0));
                end
                else
                begin
                    // Larger entries move up one slot; equal ones stay in front.
                    i = fill;
                    while (i > 0 && val < slots[i-1])
                    begin
                        slots[i] = slots[i-1];
                        i--;
                    end
                    slots[i] = val;
                    fill++;
                    batch.push_back(make(slt_pkg::ST_OK, i + 1, val, 0));
                end
            end
            else if (fill == 0)
            begin
                batch.push_back(make(slt_pkg::ST_EMPTY, 0, '0, 0));
            end
            else if (op == slt_pkg::OP_REMOVE)
            begin
                // Compact the list around every equal entry.
                keep    = 0;
                dropped = 0;
                for (i = 0; i < fill; i++)
                begin
                    if (slots[i] == val)
                        dropped++;
                    else
                        slots[keep++] = slots[i];
                end
                fill = keep;
                if (dropped == 0)
                    batch.push_back(make(slt_pkg::ST_NOT_FOUND, 0, '0, 0));
                else
                    batch.push_back(make(slt_pkg::ST_OK, 0, '0, dropped));
            end
            else if (op == slt_pkg::OP_SEARCH)
            begin
                // The scan stops at the first entry above the value.
                for (i = 0; i < fill && val >= slots[i]; i++)
                begin
                    if (slots[i] == val && batch.size() < slt_pkg::MAX_OUT)
                        batch.push_back(make(slt_pkg::ST_OK, i + 1, val, 0));
                end
                if (batch.size() == 0)
                    batch.push_back(make(slt_pkg::ST_NOT_FOUND, 0, '0, 0));
            end
            else
            begin
                for (i = 0; i < fill && batch.size() < slt_pkg::MAX_OUT; i++)
                    batch.push_back(make(slt_pkg::ST_OK, i + 1, slots[i], 0));
            end

            batch[batch.size()-1].last = 1'b1;
            foreach (batch[k]) awaited.push_back(batch[k]);
            if (fill > peak_fill) peak_fill = fill;
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("[%0t] MISMATCH %s", $time, msg);
            errors++;
        endtask

        // Compares one transferred result with the oldest one awaited.
        task check_result(logic [1:0] status, logic [slt_pkg::FW-1:0] position,
                          logic signed [slt_pkg::VW-1:0] value,
                          logic [slt_pkg::FW-1:0] removed,
                          logic [slt_pkg::FW-1:0] fill_lvl, logic last);
            outcome_t e;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected result status=%0d pos=%0d val=%0d",
                                 status, position, value));
                return;
            end
            e = awaited.pop_front();
            checked++;
            if (status !== e.status || position !== e.position || value !== e.value ||
                removed !== e.removed || fill_lvl !== e.fill || last !== e.last)
                report($sformatf({"got st=%0d pos=%0d val=%0d rm=%0d fill=%0d last=%0b, ",
                                  "want st=%0d pos=%0d val=%0d rm=%0d fill=%0d last=%0b"},
                                 status, position, value, removed, fill_lvl, last,
                                 e.status, e.position, e.value, e.removed, e.fill,
                                 e.last));
        endtask
    endclass

    logic clk;
    logic rst_n;

    slt_in_if  in_ch ();
    slt_out_if res_ch ();

    sorted_list_table_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_ch),
        .result  (res_ch)
    );

    list_scoreboard sb = new();
    int             burst_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The whole run must finish well inside this bound.
    initial
    begin
        #5000000;
        $display("FAIL sorted_list_table_top");
        $display("timeout with %0d results still awaited", sb.pending());
        $finish;
    end

    // Receiver readiness: windows of free flow, random stalls, a fixed
    // one-in-four pattern, and occasional long holds.
    initial
    begin : result_stall
        int window;
        int mode;
        int hold;
        window = 0;
        mode   = 0;
        hold   = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (window == 0)
            begin
                window = $urandom_range(16, 96);
                mode   = $urandom_range(0, 3);
            end
            window--;
            case (mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= ($urandom_range(0, 9) < 7);
                2: res_ch.ready <= (window % 4 == 0);
                default:
                begin
                    if (hold > 0)
                    begin
                        hold--;
                        res_ch.ready <= 1'b0;
                    end
                    else
                    begin
                        res_ch.ready <= 1'b1;
                        if ($urandom_range(0, 5) == 0) hold = $urandom_range(1, 8);
                    end
                end
            endcase
        end
    end

    // Every result transfer is checked against the mirror.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.status, res_ch.position, res_ch.entry_value,
                            res_ch.removed_count, res_ch.fill_level, res_ch.last);
    end

    // Values lean towards duplicates and stored entries, with extremes and noise.
    function automatic logic signed [slt_pkg::VW-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r >= 7 && sb.fill > 0)
            return sb.slots[$urandom_range(0, sb.fill - 1)];
        if (r == 4)
        begin
            case ($urandom_range(0, 4))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return -32'sd1;
                3: return 32'sd1;
                default: return 32'sd0;
            endcase
        end
        if (r == 5 || r == 6)
            return $urandom;
        return int'($urandom_range(0, 6)) - 3;
    endfunction

    // The sender works in bursts; between bursts valid drops for a while.
    task automatic pace();
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Presents one command and holds it until the transfer completes.
    task automatic issue(slt_pkg::op_t op, logic signed [slt_pkg::VW-1:0] val);
        pace();
        in_ch.valid         <= 1'b1;
        in_ch.opcode        <= op;
        in_ch.operand_value <= val;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_input(op, val);
    endtask

    initial
    begin : stimulus
        slt_pkg::op_t                  op;
        logic signed [slt_pkg::VW-1:0] val;
        logic signed [slt_pkg::VW-1:0] theme;
        bit                            draining;
        int                            r;

        rst_n               <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.opcode        <= slt_pkg::OP_INSERT;
        in_ch.operand_value <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty list, extremes, duplicates, misses, then a full list.
        issue(slt_pkg::OP_DUMP, 32'sd0);
        issue(slt_pkg::OP_SEARCH, 32'sd0);
        issue(slt_pkg::OP_REMOVE, 32'sd0);
        issue(slt_pkg::OP_INSERT, 32'sh7FFF_FFFF);
        issue(slt_pkg::OP_INSERT, 32'sh8000_0000);
        issue(slt_pkg::OP_INSERT, 32'sd0);
        issue(slt_pkg::OP_INSERT, 32'sd0);
        issue(slt_pkg::OP_INSERT, -32'sd1);
        issue(slt_pkg::OP_SEARCH, 32'sd0);
        issue(slt_pkg::OP_SEARCH, 32'sd5);
        issue(slt_pkg::OP_REMOVE, 32'sd7);
        issue(slt_pkg::OP_REMOVE, 32'sd0);
        while (sb.fill < slt_pkg::DEPTH) issue(slt_pkg::OP_INSERT, 32'sd5);
        issue(slt_pkg::OP_INSERT, 32'sd3);
        issue(slt_pkg::OP_SEARCH, 32'sd5);
        issue(slt_pkg::OP_DUMP, 32'sd0);
        issue(slt_pkg::OP_REMOVE, 32'sd5);

        // Random: alternate between filling the list around a recurring value
        // and draining it, so full, empty and long result runs keep recurring.
        draining = 1'b0;
        theme    = pick_value();
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (sb.fill == slt_pkg::DEPTH && $urandom_range(0, 2) == 0)
                draining = 1'b1;
            else if (sb.fill == 0 && draining)
            begin
                draining = 1'b0;
                theme    = pick_value();
            end
            r = $urandom_range(0, 99);
            if (!draining)
                op = (r < 55) ? slt_pkg::OP_INSERT : (r < 65) ? slt_pkg::OP_REMOVE :
                     (r < 85) ? slt_pkg::OP_SEARCH : slt_pkg::OP_DUMP;
            else
                op = (r < 20) ? slt_pkg::OP_INSERT : (r < 60) ? slt_pkg::OP_REMOVE :
                     (r < 85) ? slt_pkg::OP_SEARCH : slt_pkg::OP_DUMP;
            if (!draining && $urandom_range(0, 9) < 4)
                val = theme;
            else
                val = pick_value();
            issue(op, val);
        end
        in_ch.valid <= 1'b0;

        // Let the outstanding results arrive, then watch for stragglers.
        while (sb.pending() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Commands sent: %0d insert, %0d remove, %0d search, %0d dump.",
                 sb.op_seen[slt_pkg::OP_INSERT], sb.op_seen[slt_pkg::OP_REMOVE],
                 sb.op_seen[slt_pkg::OP_SEARCH], sb.op_seen[slt_pkg::OP_DUMP]);
        $display("%0d results checked, %0d inserts refused on a full list, peak fill %0d.",
                 sb.checked, sb.refused, sb.peak_fill);
        if (sb.errors == 0)
            $display("PASS sorted_list_table_top");
        else
            $display("FAIL sorted_list_table_top");
        $finish;
    end

endmodule
